[rtl/qpht_pkg.sv]
// Shared constants and types for the quadratic-probe hash table.
package qpht_pkg;

	localparam int TABLE_SIZE = 53;
	localparam int SLOT_W     = 6;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int SUM_W      = SLOT_W + 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
	localparam logic [SUM_W-1:0]  SIZE_SUM  = SUM_W'(TABLE_SIZE);

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_DUP       = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_UNUSED  = 2'd0,
		MARK_DELETED = 2'd1,
		MARK_USED    = 2'd2,
		MARK_BAD     = 2'd3
	} mark_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_FLUSH = 3'b100
	} fsm_t;

	// Reduce a sum below twice the table size by one compare and subtract.
	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SIZE_SUM) ? (s - SIZE_SUM) : s;
		return r[SLOT_W-1:0];
	endfunction

endpackage

[rtl/quadratic_probe_hash_table.sv]
// Open-addressing key/value table with quadratic probing and a registered result stage.
// Each accepted word probes one slot at a time from its home slot (none for the unused kind),
// then loads the result register that drives the output word.
// Words are taken one at a time, each bound by one memory read per probed slot; a stalled
// result holds off the next input until it can be loaded.
// Reset clears all slot marks to unused and the entry count to zero; keys and values are not.
module quadratic_probe_hash_table
	import qpht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // key[31:0], value[63:32], home_slot[69:64], zero pad
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // value_out[31:0], slot_index[37:32], entry_count[43:38]
	output logic [1:0]  m_tuser   // status[1:0]
);

	fsm_t                   state_q;
	kind_t                  kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [VAL_W-1:0]       val_q;
	logic [SLOT_W-1:0]      home_q;
	logic [SLOT_W-1:0]      cur_q;
	logic [SLOT_W-1:0]      step_q;
	logic [SLOT_W-1:0]      count_q;
	mark_t                  marks_q [TABLE_SIZE];
	logic [KEY_W+VAL_W-1:0] slot_data_q [TABLE_SIZE];
	logic [KEY_W+VAL_W-1:0] rd_data_q;
	mark_t                  rd_mark_q;
	status_t                res_status_q;
	logic [VAL_W-1:0]       res_val_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic                   m_tvalid_q;
	logic [47:0]            m_tdata_q;
	logic [1:0]             m_tuser_q;

	logic                   in_fire;
	logic [SLOT_W-1:0]      home_in;
	logic [SLOT_W-1:0]      nxt;
	logic [SLOT_W-1:0]      step_nxt;
	logic [SLOT_W-1:0]      rd_addr;
	mark_t                  cur_mark;
	logic                   key_hit;
	logic                   wrapped;
	logic                   stop;
	status_t                stop_status;
	logic                   do_write;
	logic                   do_delete;
	logic                   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign home_in  = wrap_slot({1'b0, s_tdata[69:64]});

	// Two add-and-wrap units step the slot and the growing probe step.
	assign nxt      = wrap_slot({1'b0, cur_q} + {1'b0, step_q});
	assign step_nxt = wrap_slot({1'b0, step_q} + SUM_W'(2));
	assign wrapped  = (nxt == home_q);
	assign cur_mark = rd_mark_q;
	assign key_hit  = (rd_data_q[KEY_W+VAL_W-1:VAL_W] == key_q);
	assign rd_addr  = (state_q == ST_IDLE) ? home_in : nxt;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		stop        = 1'b0;
		stop_status = ST_NOT_FOUND;
		do_write    = 1'b0;
		do_delete   = 1'b0;
		if (kind_q == KIND_INSERT) begin
			priority if (cur_mark != MARK_USED) begin
				stop        = 1'b1;
				stop_status = ST_DONE;
				do_write    = 1'b1;
			end else if (key_hit) begin
				stop        = 1'b1;
				stop_status = ST_DUP;
			end else if (wrapped) begin
				stop        = 1'b1;
				stop_status = ST_FULL;
			end else begin
				stop        = 1'b0;
			end
		end else begin
			priority if (cur_mark == MARK_USED && key_hit) begin
				stop        = 1'b1;
				stop_status = ST_DONE;
				do_delete   = (kind_q == KIND_REMOVE);
			end else if (cur_mark != MARK_USED && cur_mark != MARK_DELETED) begin
				stop        = 1'b1;
			end else if (wrapped) begin
				stop        = 1'b1;
			end else begin
				stop        = 1'b0;
			end
		end
	end

	// Key/value memory: at most one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		rd_data_q <= slot_data_q[rd_addr];
		rd_mark_q <= marks_q[rd_addr];
		if (state_q == ST_PROBE && do_write) begin
			slot_data_q[cur_q] <= {key_q, val_q};
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind_t'(s_tuser);
			key_q  <= s_tdata[31:0];
			val_q  <= s_tdata[63:32];
			home_q <= home_in;
			cur_q  <= home_in;
			step_q <= SLOT_W'(1);
		end else if (state_q == ST_PROBE) begin
			cur_q  <= nxt;
			step_q <= step_nxt;
		end
		if (in_fire) begin
			res_status_q <= ST_NOT_FOUND;
			res_val_q    <= '0;
			res_slot_q   <= '0;
		end else if (state_q == ST_PROBE && stop) begin
			res_status_q <= stop_status;
			res_slot_q   <= (stop_status == ST_DONE) ? cur_q : '0;
			res_val_q    <= (stop_status == ST_DONE && kind_q == KIND_LOOKUP) ?
				rd_data_q[VAL_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			for (int j = 0; j < TABLE_SIZE; j++) begin
				marks_q[j] <= MARK_UNUSED;
			end
		end else begin
			if (state_q == ST_FLUSH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						// An unused kind code skips the probe and answers not found.
						state_q <= (kind_t'(s_tuser) == KIND_NONE) ? ST_FLUSH : ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (stop) begin
						state_q <= ST_FLUSH;
						if (do_write) begin
							marks_q[cur_q] <= MARK_USED;
							count_q        <= count_q + SLOT_W'(1);
						end else if (do_delete) begin
							marks_q[cur_q] <= MARK_DELETED;
							if (count_q != '0) begin
								count_q <= count_q - SLOT_W'(1);
							end
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q    <= ST_IDLE;
						m_tdata_q  <= {4'b0, count_q, res_slot_q, res_val_q};
						m_tuser_q  <= res_status_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
